### hdl/lzd_pkg.sv
// shared constants and types for the lz77 token decompressor
package lzd_pkg;

    // default history ring depth in bytes
    localparam int HISTORY_DEPTH_DEF = 256;
    // default longest match in bytes
    localparam int MAX_MATCH_DEF = 64;
    // match length is the length code plus this bias
    localparam logic [8:0] LEN_BIAS = 9'd3;
    // produced byte count saturates here
    localparam logic [8:0] COUNT_SAT = 9'd256;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DATA
    } t_state;

endpackage

### hdl/lz77_token_decompressor.sv
// top level of the lz77 token decompressor with history ring and byte sequencer
//
// Input channel (i_valid / o_ready) takes one decoded token per beat: a literal
// byte, or a match of back distance i_data_byte and length i_length_code + 3.
// Output channel (o_valid / i_ready) gives one decompressed byte per beat, with
// o_last on the final byte of the token and o_error on every byte of a match
// with a bad distance or a length clamped to MAX_MATCH (such bytes are zero).
// One token is worked on at a time; o_ready is high only while idle.
// A literal or bad match loads each byte straight from ST_DATA. Each copied
// byte of a good match needs an ST_READ step for the registered read of the
// history ram and then an ST_DATA step to write it back and load the output
// register. o_valid rises once the first ST_DATA step of the token loads the
// output register; a good match reaches that step through ST_READ.
// Output register parts the two sides: while a byte waits on i_ready the next
// ram read is already done, and the sequencer holds only if the register is
// still full when the following byte is ready.
// Reset clears the sequencer, write pointer and byte count. The history ram is
// never cleared: the byte count keeps any read away from unwritten entries.
module lz77_token_decompressor #(
    parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_MATCH     = lzd_pkg::MAX_MATCH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_is_match,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_length_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_error
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int LW = $clog2(MAX_MATCH + 1);
    localparam logic [8:0] DEPTH9 = 9'(HISTORY_DEPTH);
    localparam logic [8:0] MAX9   = 9'(MAX_MATCH);
    localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

    lzd_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_wp, n_wp;
    logic [8:0]    r_count, n_count;
    logic [LW-1:0] r_left, n_left;
    logic [7:0]    r_data, n_data;
    logic          r_lit, n_lit;
    logic          r_err, n_err;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;
    logic          r_out_err, n_out_err;

    logic          accept;
    logic [8:0]    len9;
    logic          len_bad;
    logic          dist_bad;
    logic          can_load;
    logic [8:0]    diff9;
    logic [8:0]    src9;
    logic [AW-1:0] src;
    logic [7:0]    rdata;
    logic [7:0]    byte_val;
    logic          ram_we;

    // token checks on the incoming beat
    assign accept   = i_valid && o_ready;
    assign len9     = {1'b0, i_length_code} + lzd_pkg::LEN_BIAS;
    assign len_bad  = len9 > MAX9;
    assign dist_bad = (i_data_byte == 8'd0) || ({1'b0, i_data_byte} > r_count)
                      || ({1'b0, i_data_byte} > DEPTH9);

    // source slot: write pointer minus distance, wrapped into the ring
    assign diff9 = {{(9 - AW){1'b0}}, r_wp} - {1'b0, r_data};
    assign src9  = ({{(9 - AW){1'b0}}, r_wp} >= {1'b0, r_data}) ? diff9 : diff9 + DEPTH9;
    assign src   = src9[AW-1:0];

    // byte for this step
    assign can_load = !r_out_valid || i_ready;
    assign byte_val = r_err ? 8'd0 : (r_lit ? r_data : rdata);
    assign ram_we   = (r_state == lzd_pkg::ST_DATA) && can_load;

    lzd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (byte_val),
        .i_re    (r_state == lzd_pkg::ST_READ),
        .i_raddr (src),
        .o_rdata (rdata)
    );

    // sequencer next state and datapath
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_count     = r_count;
        n_left      = r_left;
        n_data      = r_data;
        n_lit       = r_lit;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;

        // output beat taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lzd_pkg::ST_IDLE: begin
                if (accept) begin
                    n_data = i_data_byte;
                    n_lit  = !i_is_match;
                    if (!i_is_match) begin
                        n_left  = LW'(1);
                        n_err   = 1'b0;
                        n_state = lzd_pkg::ST_DATA;
                    end else begin
                        n_left  = len_bad ? LW'(MAX_MATCH) : LW'(len9);
                        n_err   = len_bad || dist_bad;
                        n_state = (len_bad || dist_bad) ? lzd_pkg::ST_DATA
                                                        : lzd_pkg::ST_READ;
                    end
                end
            end
            lzd_pkg::ST_READ: begin
                n_state = lzd_pkg::ST_DATA;
            end
            lzd_pkg::ST_DATA: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = byte_val;
                    n_out_last  = (r_left == LW'(1));
                    n_out_err   = r_err;
                    n_wp        = (r_wp == WP_LAST) ? '0 : r_wp + AW'(1);
                    if (r_count != lzd_pkg::COUNT_SAT) begin
                        n_count = r_count + 9'd1;
                    end
                    n_left = r_left - LW'(1);
                    if (r_left == LW'(1)) begin
                        n_state = lzd_pkg::ST_IDLE;
                    end else if (r_err || r_lit) begin
                        n_state = lzd_pkg::ST_DATA;
                    end else begin
                        n_state = lzd_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = lzd_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzd_pkg::ST_IDLE;
            r_wp        <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_lit      <= n_lit;
        r_err      <= n_err;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    assign o_ready    = (r_state == lzd_pkg::ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;
    assign o_error    = r_out_err;

    // a ram read is always followed by the cycle that consumes it
    a_read_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzd_pkg::ST_READ) |=> (r_state == lzd_pkg::ST_DATA))
        else $error("ram read not followed by data step");

    // bytes of a bad token are zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_byte == 8'd0))
        else $error("error beat carries nonzero byte");

    // a busy sequencer always has bytes left to emit
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lzd_pkg::ST_IDLE) |-> (r_left != '0))
        else $error("sequencer busy with no bytes left");

    // byte count never passes saturation
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= lzd_pkg::COUNT_SAT))
        else $error("byte count above saturation");

    // a token ends in idle with its last byte loaded
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzd_pkg::ST_DATA && can_load && r_left == LW'(1))
        |=> (r_state == lzd_pkg::ST_IDLE && r_out_valid && r_out_last))
        else $error("final byte did not close the token");

endmodule

### hdl/lzd_ram.sv
// generic single write port ram with registered read
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
